[rtl/assert_macros.svh]
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PNR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define PNR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/pnr_pkg.sv]
// types, constants and state encoding for the nearest-neighbor resampler
// no dependencies
package pnr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int STEP_W = 21;
	localparam int MAX_RUN = 64;
	localparam int CNT_W = $clog2(MAX_RUN);
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_WIDE_SAMPLES = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TWO_CHANNELS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

	typedef struct packed {
		logic [15:0] first_word;
		logic [15:0] second_word;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_WRAP
	} pnr_state_t;

endpackage

[rtl/pcm_nearest_resampler_core.sv]
// output: first result in the cycle after a frame transaction; a skipped frame yields none
// flow: no new frame is taken while results are emitted; at most 64 results per frame;
// the single phase adder handles one result per cycle while out_stall is low
// reset: async active low; phase cleared, registers to 16-bit stereo with unit step
module pcm_nearest_resampler_core #(
	parameter int FRAC_BITS = pnr_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [pnr_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [pnr_pkg::STEP_W-1:0] wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  pnr_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output pnr_pkg::out_item_t out_data
);
	import pnr_pkg::*;

	localparam int PHASE_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
	localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
	localparam logic [PHASE_W-1:0] PHASE_MINUS_ONE = ~PHASE_ONE + PHASE_W'(1);

	pnr_state_t state_q, state_nxt;

	logic wide_q;
	logic two_ch_q;
	logic [STEP_W-1:0] step_q;
	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;

	logic signed [15:0] conv_left;
	logic signed [15:0] conv_right;
	logic [PHASE_W-1:0] alu_operand;
	logic [PHASE_W-1:0] alu_sum;
	logic phase_ge_one;
	logic sum_ge_one;
	logic run_last;
	logic in_take;
	logic out_take;
	logic use_step;

	pnr_frame_conv u_conv (
		.wide_samples(wide_q),
		.two_channels(two_ch_q),
		.frame(in_data),
		.left_sample(conv_left),
		.right_sample(conv_right)
	);

	// shared phase adder: add the step while emitting, take off one otherwise
	assign alu_operand = use_step ? PHASE_W'(step_q) : PHASE_MINUS_ONE;
	assign alu_sum = phase_q + alu_operand;
	assign phase_ge_one = (phase_q >= PHASE_ONE);
	assign sum_ge_one = (alu_sum >= PHASE_ONE);
	assign run_last = sum_ge_one || (cnt_q == CNT_W'(MAX_RUN - 1));

	assign in_take = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && !phase_ge_one)
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_take && run_last)
					state_nxt = ST_WRAP;
			end
			ST_WRAP: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		out_valid = 1'b0;
		use_step = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_EMIT: begin
				out_valid = 1'b1;
				use_step = 1'b1;
			end
			ST_WRAP: ;
			default: ;
		endcase
	end

	assign out_data.left_sample = left_q;
	assign out_data.right_sample = right_q;
	assign out_data.last_of_run = run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wide_q <= 1'b1;
			two_ch_q <= 1'b1;
			step_q <= STEP_RESET;
			phase_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				case (wr_index)
					REG_WIDE_SAMPLES: wide_q <= wr_data[0];
					REG_TWO_CHANNELS: two_ch_q <= wr_data[0];
					REG_PHASE_STEP: step_q <= wr_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_take && phase_ge_one)
						phase_q <= alu_sum;
				end
				ST_EMIT: begin
					if (out_take) begin
						phase_q <= alu_sum;
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_WRAP: phase_q <= phase_ge_one ? alu_sum : '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			left_q <= conv_left;
			right_q <= conv_right;
		end
	end

endmodule

[rtl/pnr_frame_conv.sv]
// source frame to signed 16-bit stereo pair conversion
// depends on pnr_pkg
module pnr_frame_conv (
	input  logic wide_samples,
	input  logic two_channels,
	input  pnr_pkg::in_item_t frame,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample
);
	import pnr_pkg::*;

	logic [15:0] byte_lo;
	logic [15:0] byte_hi;

	// (b - 128) << 8 is the byte with its top bit flipped, shifted up
	assign byte_lo = {~frame.first_word[7], frame.first_word[6:0], 8'h00};
	assign byte_hi = {~frame.first_word[15], frame.first_word[14:8], 8'h00};

	always_comb begin
		if (wide_samples) begin
			left_sample = frame.first_word;
			right_sample = two_channels ? frame.second_word : frame.first_word;
		end else begin
			left_sample = byte_lo;
			right_sample = two_channels ? byte_hi : byte_lo;
		end
	end

endmodule

[rtl/pnr_checker.sv]
// port-level checks for the resampler core, bound to the top level
// depends on pnr_pkg and assert_macros.svh
`include "assert_macros.svh"

module pnr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input pnr_pkg::out_item_t out_data
);
	import pnr_pkg::*;

	`PNR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`PNR_ASSERT_NOW(a_no_take_while_emit, clk, arst_n, out_valid, in_stall)
	`PNR_ASSERT_NEXT(a_gap_after_last, clk, arst_n, out_valid && !out_stall && out_data.last_of_run, !out_valid)
	`PNR_ASSERT_NEXT(a_run_continues, clk, arst_n, out_valid && !out_stall && !out_data.last_of_run, out_valid)

endmodule

bind pcm_nearest_resampler_core pnr_checker u_pnr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
